FILE: hw/rtl/mlpr_pkg.sv
// Package for the MLP forward pass: sizes, Q8.8 constants, opcodes, states,
// the cell control and data chain structs, and register clamp helpers.
// No dependencies.
`default_nettype none
package mlpr_pkg;
	localparam int unsigned NEURONS = 16;
	localparam int unsigned WLAYERS = 4;
	localparam int unsigned DW      = 16;
	localparam int unsigned FRAC    = 8;
	localparam int unsigned IDX_W   = $clog2(NEURONS);
	localparam int unsigned LIDX_W  = $clog2(WLAYERS);
	localparam int unsigned PROD_W  = 2 * DW;
	localparam int unsigned ACC_W   = PROD_W + IDX_W + 1;
	localparam int unsigned RES_W   = DW - 1;
	localparam int unsigned CNT_W   = $clog2(NEURONS + 3);
	localparam int unsigned DRAIN_CYC = NEURONS + 2;

	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_INPUT  = 2'd2,
		OP_RUN    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		REG_NUM_LAYERS = 3'd0,
		REG_SIZE0      = 3'd1,
		REG_SIZE4      = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_FEED,
		ST_DRAIN,
		ST_WRITE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic [IDX_W-1:0]     idx;
		logic signed [DW-1:0] act;
	} flow_t;

	typedef struct packed {
		logic              start;
		logic [LIDX_W-1:0] lidx;
		logic              load_w;
		logic              load_b;
		logic [LIDX_W-1:0] wl;
		logic [IDX_W-1:0]  col;
		logic [DW-1:0]     value;
	} cell_ctrl_t;

	function automatic logic [4:0] size_clamp(input logic [4:0] s);
		if (s == 5'd0) return 5'd1;
		if (s > 5'(NEURONS)) return 5'(NEURONS);
		return s;
	endfunction

	function automatic logic [2:0] layers_clamp(input logic [2:0] n);
		if (n == 3'd0) return 3'd1;
		if (n > 3'(WLAYERS)) return 3'(WLAYERS);
		return n;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/mlpr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module mlpr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/mlpr_cell.sv
// One neuron cell: holds its weight row for every layer and its biases,
// accumulates products as activations pass by, and forwards them on.
// Depends on mlpr_pkg and mlpr_ram.
`default_nettype none
module mlpr_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mlpr_pkg::cell_ctrl_t             ctrl,
	input  wire logic                             sel,
	input  wire mlpr_pkg::flow_t                  flow_in,
	output mlpr_pkg::flow_t                       flow_out,
	output logic [mlpr_pkg::RES_W-1:0]            res
);
	import mlpr_pkg::*;

	flow_t                     pass_q;
	logic [DW-1:0]             wdata_rd;
	logic [DW-1:0]             bias_q [WLAYERS];
	logic signed [PROD_W-1:0]  mul_s2;
	logic                      mv_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ACC_W-FRAC-1:0]     quot;
	logic [DW-1:0]             bias_sel;

	mlpr_ram #(.WIDTH(DW), .DEPTH(WLAYERS * NEURONS)) u_wram (
		.clk  (clk),
		.we   (ctrl.load_w && sel),
		.waddr({ctrl.wl, ctrl.col}),
		.wdata(ctrl.value),
		.raddr({ctrl.lidx, flow_in.idx}),
		.rdata(wdata_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
			mv_s2  <= 1'b0;
		end else begin
			pass_q <= flow_in;
			mv_s2  <= pass_q.valid;
		end
	end

	assign bias_sel = bias_q[ctrl.lidx];

	always_ff @(posedge clk) begin
		mul_s2     <= $signed(wdata_rd) * $signed(pass_q.act);
		if (ctrl.load_b && sel) begin
			bias_q[ctrl.wl] <= ctrl.value;
		end
		// The bias enters in Q16.16, aligned with the products.
		if (ctrl.start) begin
			acc_q <= $signed({{(ACC_W-DW-FRAC){bias_sel[DW-1]}}, bias_sel, {FRAC{1'b0}}});
		end else if (mv_s2) begin
			acc_q <= acc_q + $signed({{(ACC_W-PROD_W){mul_s2[PROD_W-1]}}, mul_s2});
		end
	end

	assign flow_out = pass_q;
	assign quot     = acc_q[ACC_W-1:FRAC];

	always_comb begin
		if (acc_q[ACC_W-1] || acc_q == '0) begin
			res = '0;
		end else if (|quot[ACC_W-FRAC-1:RES_W]) begin
			res = '1;
		end else begin
			res = quot[RES_W-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/mlp_relu_forward.sv
// MLP forward pass with ReLU on every layer.
// Input items on item_valid/item_stall either load a weight, a bias or an
// input activation (one per cycle, no result) or start a run. Loads are taken
// in any idle cycle; item_stall is high for the whole run.
// A run computes layer after layer in a chain of 16 neuron cells: the previous
// layer's activations enter the first cell one per cycle and travel down the
// chain, each cell multiplying by its own weight and accumulating. Each layer
// steps through start, feed and the chain drain of cells plus multiply stages,
// then writes back unless it is the last. The output layer then leaves on
// result_valid/result_stall, one neuron per item, last marking the final one;
// a stalled result holds in the output register and the run waits.
// Configuration writes on cfg_valid/cfg_ready are always ready and are to be
// done while no run is in progress. Reset clears control state and restores
// two layers of 16 neurons; weight, bias and input stores are undefined until
// loaded. With three or more layers the inputs are overwritten by layer two.
// Depends on mlpr_pkg and mlpr_cell.
`default_nettype none
module mlp_relu_forward (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    opcode,
	input  wire logic [2:0]                    layer,
	input  wire logic [3:0]                    row,
	input  wire logic [3:0]                    col,
	input  wire logic signed [15:0]            value,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [3:0]                         neuron,
	output logic [14:0]                        activation,
	output logic                               last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [4:0]                    cfg_data
);
	import mlpr_pkg::*;

	state_t            state_q, state_d;
	logic [2:0]        nwl_q;
	logic [4:0]        size_q [WLAYERS+1];
	logic [DW-1:0]     act_q [2][NEURONS];
	logic [LIDX_W-1:0] layer_q;
	logic [CNT_W-1:0]  cnt_q;
	cell_ctrl_t        ctrl;
	flow_t             feed;
	flow_t             flow [NEURONS+1];
	logic [RES_W-1:0]  res [NEURONS];
	logic [NEURONS-1:0] sel;
	logic              accept;
	logic [4:0]        prev_sz, cur_sz;
	logic [2:0]        nl;
	logic              last_layer;
	logic              out_free;
	logic              emit_last;
	logic              layer_ok;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid && !item_stall;
	assign nl        = layers_clamp(nwl_q);
	assign prev_sz   = size_clamp(size_q[layer_q]);
	assign cur_sz    = size_clamp(size_q[{1'b0, layer_q} + 3'd1]);
	assign last_layer = ({1'b0, layer_q} + 3'd1) == nl;
	assign out_free  = !result_valid || !result_stall;
	assign emit_last = cnt_q == (cur_sz - 5'd1);
	assign layer_ok  = layer != 3'd0 && layer <= 3'(WLAYERS);
	assign flow[0]   = feed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nwl_q <= 3'd2;
			for (int k = 0; k <= WLAYERS; k++) begin
				size_q[k] <= 5'(NEURONS);
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NUM_LAYERS) begin
				nwl_q <= cfg_data[2:0];
			end else if (cfg_index <= REG_SIZE4) begin
				size_q[cfg_index - REG_SIZE0] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		item_stall   = 1'b1;
		ctrl.start   = 1'b0;
		ctrl.lidx    = layer_q;
		ctrl.load_w  = 1'b0;
		ctrl.load_b  = 1'b0;
		ctrl.wl      = LIDX_W'(layer - 3'd1);
		ctrl.col     = col;
		ctrl.value   = value;
		feed.valid   = 1'b0;
		feed.idx     = cnt_q[IDX_W-1:0];
		feed.act     = act_q[layer_q[0]][cnt_q[IDX_W-1:0]];
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (accept) begin
					ctrl.load_w = opcode == OP_WEIGHT && layer_ok;
					ctrl.load_b = opcode == OP_BIAS && layer_ok;
					if (opcode == OP_RUN) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				ctrl.start = 1'b1;
				state_d    = ST_FEED;
			end
			ST_FEED: begin
				feed.valid = 1'b1;
				if (cnt_q == prev_sz - 5'd1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == CNT_W'(DRAIN_CYC - 1)) begin
					state_d = last_layer ? ST_EMIT : ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = ST_START;
			end
			ST_EMIT: begin
				if (out_free && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_q <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					layer_q <= '0;
					cnt_q   <= '0;
				end
				ST_START: cnt_q <= '0;
				ST_FEED, ST_DRAIN: begin
					cnt_q <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
				end
				ST_WRITE: layer_q <= layer_q + 1'b1;
				ST_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// Inputs load into bank 0; layer l reads bank (l-1) mod 2, writes l mod 2.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && opcode == OP_INPUT) begin
			act_q[0][row] <= value;
		end else if (state_q == ST_WRITE) begin
			for (int j = 0; j < NEURONS; j++) begin
				if (5'(j) < cur_sz) begin
					act_q[~layer_q[0]][j] <= DW'(res[j]);
				end
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < NEURONS; g++) begin : g_cell
			assign sel[g] = row == IDX_W'(g);
			mlpr_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.sel     (sel[g]),
				.flow_in (flow[g]),
				.flow_out(flow[g+1]),
				.res     (res[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= state_q == ST_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			neuron     <= cnt_q[IDX_W-1:0];
			activation <= res[cnt_q[IDX_W-1:0]];
			last       <= emit_last;
		end
	end
endmodule
`default_nettype wire

FILE: sim/tb_mlp_relu_forward.sv
// Self-checking testbench for mlp_relu_forward: loads weights, biases and inputs,
// starts forward passes under several layer configurations and checks every output neuron.
// Depends on mlpr_pkg and the mlp_relu_forward RTL.
`timescale 1ns / 100ps
module tb_mlp_relu_forward;
	import mlpr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		opcode_t            op;
		logic [2:0]         layer;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [15:0] value;
	} nn_item_t;

	typedef struct {
		logic [3:0]  neuron;
		logic [14:0] activation;
		logic        last;
	} neuron_out_t;

	logic clk, arst_n;
	logic item_valid, item_stall;
	logic [1:0] opcode;
	logic [2:0] layer;
	logic [3:0] row, col;
	logic signed [15:0] value;
	logic result_valid, result_stall;
	logic [3:0] neuron;
	logic [14:0] activation;
	logic last;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [4:0] cfg_data;

	mlp_relu_forward i_dut (.*);

	// Shadow of the block's stores and registers.
	logic signed [15:0] w_mem [1024];
	logic signed [15:0] b_mem [64];
	logic signed [15:0] a_mem [32];
	logic [2:0] layers_reg;
	logic [4:0] size_reg [5];

	// Which entries the stimulus has already written, in generation order.
	bit w_set [1024];
	bit b_set [64];
	bit a_set [32];

	nn_item_t    pending [$];
	neuron_out_t expected_outs [$];
	int unsigned errors, cycles, runs_done, outs_seen;
	int unsigned send_gap, stall_gap;
	bit          idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned eff_size(int unsigned l);
		if (l > 4) return 1;
		if (size_reg[l] == 0) return 1;
		if (size_reg[l] > 16) return 16;
		return size_reg[l];
	endfunction

	function automatic int unsigned eff_layers();
		if (layers_reg == 0) return 1;
		if (layers_reg > 4) return 4;
		return layers_reg;
	endfunction

	function automatic void forward_pass();
		int unsigned nl, prev, cur, src, dst;
		longint acc;
		longint res [16];
		neuron_out_t o;
		nl = eff_layers();
		for (int unsigned l = 1; l <= nl; l++) begin
			prev = eff_size(l - 1);
			cur = eff_size(l);
			src = ((l - 1) % 2) * 16;
			dst = (l % 2) * 16;
			for (int unsigned j = 0; j < cur; j++) begin
				acc = 0;
				for (int unsigned i = 0; i < prev; i++)
					acc += longint'(w_mem[(l - 1) * 256 + j * 16 + i]) * longint'(a_mem[src + i]);
				acc += longint'(b_mem[(l - 1) * 16 + j]) * 256;
				if (acc <= 0) res[j] = 0;
				else begin
					res[j] = acc >>> 8;
					if (res[j] > 32767) res[j] = 32767;
				end
			end
			for (int unsigned j = 0; j < cur; j++) begin
				if (l == nl) begin
					o.neuron = j[3:0];
					o.activation = res[j][14:0];
					o.last = (j + 1 == cur);
					expected_outs = {expected_outs, o};
				end else
					a_mem[dst + j] = res[j][15:0];
			end
		end
	endfunction

	function automatic void apply_item(opcode_t op, logic [2:0] l, logic [3:0] r,
			logic [3:0] c, logic signed [15:0] v);
		case (op)
			OP_WEIGHT: if (l >= 1 && l <= 4) w_mem[(l - 1) * 256 + r * 16 + c] = v;
			OP_BIAS: if (l >= 1 && l <= 4) b_mem[(l - 1) * 16 + r] = v;
			OP_INPUT: a_mem[r] = v;
			OP_RUN: begin
				forward_pass();
				runs_done++;
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// Item driver and accept-time prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			opcode <= OP_WEIGHT;
			layer <= '0;
			row <= '0;
			col <= '0;
			value <= '0;
			send_gap <= 0;
		end else begin
			if (item_valid && !item_stall)
				apply_item(opcode_t'(opcode), layer, row, col, value);
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (idle_on && $urandom_range(7) == 0) begin
					send_gap <= $urandom_range(1, 13) - 1;
					item_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					nn_item_t it;
					it = pending.pop_front();
					item_valid <= 1'b1;
					opcode <= it.op;
					layer <= it.layer;
					row <= it.row;
					col <= it.col;
					value <= it.value;
				end else
					item_valid <= 1'b0;
			end
		end
	end

	// Result stall generator, result checker and timeout.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_gap <= 0;
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("** mlp_relu_forward: FAILED **");
				$finish;
			end
			if (stall_gap > 0) begin
				stall_gap <= stall_gap - 1;
				result_stall <= 1'b1;
			end else if (idle_on && $urandom_range(5) == 0) begin
				stall_gap <= $urandom_range(1, 13) - 1;
				result_stall <= 1'b1;
			end else
				result_stall <= 1'b0;
			if (result_valid && !result_stall) begin
				outs_seen++;
				if (expected_outs.size() == 0) begin
					report_mismatch("unexpected item, neuron", int'(neuron), -1);
				end else begin
					neuron_out_t e;
					e = expected_outs.pop_front();
					if (neuron !== e.neuron) report_mismatch("neuron", neuron, e.neuron);
					if (activation !== e.activation)
						report_mismatch("activation", activation, e.activation);
					if (last !== e.last) report_mismatch("last", last, e.last);
				end
			end
		end
	end

	task automatic add_item(opcode_t op, logic [2:0] l, logic [3:0] r, logic [3:0] c,
			logic signed [15:0] v);
		nn_item_t it;
		it.op = op;
		it.layer = l;
		it.row = r;
		it.col = c;
		it.value = v;
		pending = {pending, it};
		if (op == OP_WEIGHT && l >= 1 && l <= 4) w_set[(l - 1) * 256 + r * 16 + c] = 1;
		if (op == OP_BIAS && l >= 1 && l <= 4) b_set[(l - 1) * 16 + r] = 1;
		if (op == OP_INPUT) a_set[r] = 1;
	endtask

	// Loads whatever a forward pass would read that was never written, then starts it.
	// With fixed set, every entry the pass reads is rewritten with fill_val.
	task automatic add_run(bit fixed, logic signed [15:0] fill_val);
		int unsigned nl, prev, cur;
		logic signed [15:0] v;
		nl = eff_layers();
		for (int unsigned l = 1; l <= nl; l++) begin
			prev = eff_size(l - 1);
			cur = eff_size(l);
			for (int unsigned j = 0; j < cur; j++) begin
				for (int unsigned i = 0; i < prev; i++)
					if (fixed || !w_set[(l - 1) * 256 + j * 16 + i]) begin
						v = fixed ? fill_val : 16'($urandom_range(0, 1023) - 512);
						add_item(OP_WEIGHT, 3'(l), 4'(j), 4'(i), v);
					end
				if (fixed || !b_set[(l - 1) * 16 + j]) begin
					v = fixed ? fill_val : 16'($urandom_range(0, 2047) - 1024);
					add_item(OP_BIAS, 3'(l), 4'(j), 4'(0), v);
				end
			end
			if (l == 1)
				for (int unsigned i = 0; i < prev; i++)
					if (fixed || !a_set[i])
						add_item(OP_INPUT, 3'(0), 4'(i), 4'(0),
							fixed ? fill_val : 16'($urandom_range(0, 1023)));
			if (l < nl)
				for (int unsigned j = 0; j < cur; j++) a_set[(l % 2) * 16 + j] = 1;
		end
		add_item(OP_RUN, 3'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
	endtask

	task automatic write_reg(logic [2:0] idx, logic [4:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_NUM_LAYERS) layers_reg = data[2:0];
		else if (idx <= REG_SIZE4) size_reg[idx - REG_SIZE0] = data;
	endtask

	// Sampled at the falling edge, after the driver's updates have settled.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending.size() != 0 || item_valid || expected_outs.size() != 0);
		repeat (DRAIN_CYC * 5 * 4) @(posedge clk);
	endtask

	task automatic random_items(int unsigned count);
		int unsigned pick;
		for (int unsigned k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 36)
				add_item(OP_WEIGHT, 3'($urandom_range(1, 4)), 4'($urandom), 4'($urandom),
					16'($urandom));
			else if (pick < 40)
				add_item(pick < 38 ? OP_WEIGHT : OP_BIAS, 3'($urandom_range(0, 1) ? 0
					: $urandom_range(5, 7)), 4'($urandom), 4'($urandom), 16'($urandom));
			else if (pick < 58)
				add_item(OP_BIAS, 3'($urandom_range(1, 4)), 4'($urandom), 4'($urandom),
					16'($urandom));
			else if (pick < 85)
				add_item(OP_INPUT, 3'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
			else
				add_run(1'b0, 16'sd0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		errors = 0;
		runs_done = 0;
		outs_seen = 0;
		layers_reg = 3'd2;
		foreach (size_reg[i]) size_reg[i] = 5'd16;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: saturation, all-negative inputs, out-of-range load layers, with the
		// reset layer count and three-neuron layers.
		write_reg(REG_SIZE0, 5'd3);
		write_reg(REG_SIZE0 + 3'd1, 5'd3);
		add_run(1'b1, 16'sh7FFF);
		for (int unsigned i = 0; i < 16; i++)
			add_item(OP_INPUT, 3'd7, 4'(i), 4'd15, 16'sh8000);
		add_run(1'b0, 16'sd0);
		add_item(OP_WEIGHT, 3'd0, 4'd15, 4'd15, 16'sh7FFF);
		add_item(OP_WEIGHT, 3'd5, 4'd0, 4'd0, 16'sh8000);
		add_item(OP_BIAS, 3'd7, 4'd15, 4'd0, 16'sh7FFF);
		add_item(OP_BIAS, 3'd0, 4'd3, 4'd9, 16'sh8000);
		add_run(1'b0, 16'sd0);
		add_run(1'b1, -16'sd256);
		wait_idle();

		// Phases over several layer settings, extremes first.
		for (int unsigned ph = 0; ph < 7; ph++) begin
			idle_on = (ph != 6) && (ph != 3);
			case (ph)
				0: begin
					write_reg(REG_NUM_LAYERS, 5'd4);
					for (int unsigned s = 0; s < 5; s++)
						write_reg(REG_SIZE0 + 3'(s), (s == 0 || s == 4) ? 5'd16 : 5'd1);
				end
				1: begin
					write_reg(REG_NUM_LAYERS, 5'd0);
					for (int unsigned s = 0; s < 5; s++) write_reg(REG_SIZE0 + 3'(s), 5'd0);
				end
				2: begin
					write_reg(REG_NUM_LAYERS, 5'd7);
					for (int unsigned s = 0; s < 5; s++)
						write_reg(REG_SIZE0 + 3'(s), (s == 0 || s == 4) ? 5'd31 : 5'd0);
					write_reg(REG_SPARE_LO, 5'd1);
					write_reg(REG_SPARE_HI, 5'd2);
				end
				default: begin
					write_reg(REG_NUM_LAYERS, 5'($urandom_range(0, 7)));
					for (int unsigned s = 0; s < 5; s++)
						write_reg(REG_SIZE0 + 3'(s), 5'($urandom_range(0, 6)));
				end
			endcase
			random_items(24);
			wait_idle();
		end

		$display("forward passes: %0d, output neurons checked: %0d, mismatches: %0d",
			runs_done, outs_seen, errors);
		$display("layer counts 1 to 4, sizes 1 to 16 with out-of-range register values");
		if (errors == 0)
			$display("** mlp_relu_forward: PASSED **");
		else
			$display("** mlp_relu_forward: FAILED **");
		$finish;
	end
endmodule
